/* design/sdtc_pkg.sv */
// shared types and constants of the scaled day-time clock
// no dependencies; imported by sdtc_div and scaled_day_time_clock_top
package sdtc_pkg;

  // time constants in milliseconds
  localparam logic [27:0] MS_PER_SEC  = 28'd1000;
  localparam logic [27:0] MS_PER_MIN  = 28'd60000;
  localparam logic [27:0] MS_PER_HOUR = 28'd3600000;
  localparam logic [27:0] MS_PER_DAY  = 28'd86400000;

  // request kinds
  localparam logic [1:0] REQ_SET_ABS = 2'd0;
  localparam logic [1:0] REQ_SET_DAY = 2'd1;
  localparam logic [1:0] REQ_STEP    = 2'd2;
  localparam logic [1:0] REQ_ADVANCE = 2'd3;

  // step units
  localparam logic [2:0] UNIT_MS   = 3'd0;
  localparam logic [2:0] UNIT_SEC  = 3'd1;
  localparam logic [2:0] UNIT_MIN  = 3'd2;
  localparam logic [2:0] UNIT_HOUR = 3'd3;
  localparam logic [2:0] UNIT_DAY  = 3'd4;

  // shared divider widths
  localparam int DIV_NUM_W = 28;
  localparam int DIV_DEN_W = 42;
  localparam int DIV_QUO_W = 26;
  localparam int DIV_CNT_W = 5;

  // quotient bit counts for each division
  localparam logic [DIV_CNT_W-1:0] STEPS_RATE = 5'd26;
  localparam logic [DIV_CNT_W-1:0] STEPS_HOUR = 5'd5;
  localparam logic [DIV_CNT_W-1:0] STEPS_MIN  = 5'd6;
  localparam logic [DIV_CNT_W-1:0] STEPS_SEC  = 5'd6;

  // command to the shared divider
  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;    // divisor already shifted to the top quotient bit
    logic [DIV_CNT_W-1:0] steps;
  } div_cmd_t;

endpackage

/* design/sdtc_div.sv */
// shared restoring divider: one compare and subtract per cycle
// depends on sdtc_pkg
module sdtc_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  sdtc_pkg::div_cmd_t       cmd,
  output logic                     busy,
  output logic [sdtc_pkg::DIV_QUO_W-1:0] quo,
  output logic [sdtc_pkg::DIV_NUM_W-1:0] rem
);
  import sdtc_pkg::*;

  logic [DIV_NUM_W-1:0] rem_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_QUO_W-1:0] quo_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 fits;

  // trial compare of remainder against shifted divisor
  assign fits = {{(DIV_DEN_W-DIV_NUM_W){1'b0}}, rem_r} >= den_r;

  // iteration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.start) begin
      rem_r <= cmd.num;
      den_r <= cmd.den;
      quo_r <= '0;
      cnt_r <= cmd.steps;
    end else if (cnt_r != '0) begin
      if (fits) begin
        rem_r <= rem_r - den_r[DIV_NUM_W-1:0];
      end
      quo_r <= {quo_r[DIV_QUO_W-2:0], fits};
      den_r <= den_r >> 1;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign busy = (cnt_r != '0);
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

/* design/scaled_day_time_clock_top.sv */
// top level of the scaled day-time clock: request sequencer and clock state
// depends on sdtc_pkg and sdtc_div
//
// Usage:
//   in_*  : one request per transaction; in_tuser carries the request kind,
//           in_tdata the set values, the real milliseconds and the step fields.
//   out_* : one result per request with the decoded time; out_tuser is the
//           accepted flag.
//   cfg_* : write of the real-milliseconds-per-virtual-second register
//           (always ready; write only while no request is in flight).
// Sequence: the shared divider does the work of each request: 26 quotient
//   steps for the rate scaling of advance requests, then 5 + 6 + 6 steps to
//   decode hours, minutes and seconds. in_tready is high only when the
//   sequencer is idle, so a new request is accepted only after the previous
//   one has loaded its result into the output register.
// Reset: day count and time of day go to zero, the rate register to 1000.
// Stall: a finished result waits in the output register; the next request
//   may already be accepted and runs until its own result must be loaded.
module scaled_day_time_clock_top #(
  parameter int DAY_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // day_value, hour_value, minute_value, second_value,
                                  // milli_value, step_unit, step_down, zero fill
  input  logic [1:0]  in_tuser,   // req_type
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // day_now, hour_now, minute_now, second_now,
                                  // milli_now, ms_of_day, zero fill
  output logic [0:0]  out_tuser,  // accepted
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import sdtc_pkg::*;

  localparam int CW = (DAY_BITS > 16) ? DAY_BITS : 16;
  localparam logic [DAY_BITS-1:0] DAY_MAX = {DAY_BITS{1'b1}};

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_SET_B, S_SET_C, S_RATE_WAIT, S_ADD,
    S_DEC_H, S_WAIT_H, S_WAIT_M, S_WAIT_S, S_OUT
  } state_t;

  state_t               state_r;
  logic [DAY_BITS-1:0]  day_count_r;
  logic [26:0]          day_millis_r;
  logic [15:0]          rate_r;

  // captured request
  logic [1:0]           req_r;
  logic [15:0]          day_r;
  logic [7:0]           h_r, m_r, s_r;
  logic [15:0]          ms_r;
  logic [2:0]           unit_r;
  logic                 down_r;

  logic [26:0]          acc_r;
  logic                 ok_r;
  logic [4:0]           hour_r;
  logic [5:0]           min_r;
  logic [5:0]           sec_r;

  logic                 out_valid_r;
  logic [71:0]          out_data_r;
  logic                 out_user_r;

  // shared divider
  div_cmd_t             div_cmd;
  logic                 div_busy;
  logic [DIV_QUO_W-1:0] div_quo;
  logic [DIV_NUM_W-1:0] div_rem;

  sdtc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (div_cmd),
    .busy  (div_busy),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // combinational helpers
  logic [15:0]         rate_eff;
  logic [25:0]         real_scaled;
  logic                set_valid;
  logic [26:0]         set_a, set_b, set_c;
  logic [CW-1:0]       day_ext;
  logic [DAY_BITS-1:0] day_sat;
  logic [27:0]         dm_ext, step_d, addend, sum, sum_wrap, dm_diff;
  logic                roll;
  logic [DAY_BITS-1:0] day_roll;
  logic                step_ok;
  logic [26:0]         step_dm;
  logic [DAY_BITS-1:0] step_day;
  logic [CW-1:0]       day_now_ext;

  assign rate_eff    = (rate_r == 16'd0) ? 16'd1 : rate_r;
  assign real_scaled = 26'(ms_r) * 26'd1000;

  // set value check and horner evaluation of the time of day
  assign set_valid = (h_r < 8'd24) && (m_r < 8'd60) && (s_r < 8'd60) && (ms_r < 16'd1000);
  assign set_a     = 27'(h_r) * 27'd60 + 27'(m_r);
  assign set_b     = acc_r * 27'd60 + 27'(s_r);
  assign set_c     = acc_r * 27'd1000 + 27'(ms_r);
  assign day_ext   = CW'(day_r);
  assign day_sat   = (day_ext > CW'(DAY_MAX)) ? DAY_MAX : day_ext[DAY_BITS-1:0];

  // unit size for steps
  always_comb begin
    unique case (unit_r)
      UNIT_MS:   step_d = 28'd1;
      UNIT_SEC:  step_d = MS_PER_SEC;
      UNIT_MIN:  step_d = MS_PER_MIN;
      default:   step_d = MS_PER_HOUR;
    endcase
  end

  // add with midnight rollover, shared by steps and advances
  assign dm_ext   = {1'b0, day_millis_r};
  assign addend   = (state_r == S_ADD) ? 28'(div_quo) : step_d;
  assign sum      = dm_ext + addend;
  assign roll     = (sum >= MS_PER_DAY);
  assign sum_wrap = roll ? (sum - MS_PER_DAY) : sum;
  assign day_roll = (roll && day_count_r != DAY_MAX) ? day_count_r + 1'b1 : day_count_r;
  assign dm_diff  = dm_ext - step_d;

  // step request outcome
  always_comb begin
    step_ok  = 1'b0;
    step_dm  = day_millis_r;
    step_day = day_count_r;
    priority if (unit_r <= UNIT_HOUR && !down_r) begin
      step_ok  = 1'b1;
      step_dm  = sum_wrap[26:0];
      step_day = day_roll;
    end else if (unit_r <= UNIT_HOUR && dm_ext >= step_d) begin
      step_ok = 1'b1;
      step_dm = dm_diff[26:0];
    end else if (unit_r == UNIT_HOUR && day_count_r != '0) begin
      step_ok  = 1'b1;
      step_dm  = day_millis_r + 27'd82800000;
      step_day = day_count_r - 1'b1;
    end else if (unit_r == UNIT_DAY && !down_r && day_count_r != DAY_MAX) begin
      step_ok  = 1'b1;
      step_day = day_count_r + 1'b1;
    end else if (unit_r == UNIT_DAY && down_r && day_count_r != '0) begin
      step_ok  = 1'b1;
      step_day = day_count_r - 1'b1;
    end else begin
      step_ok = 1'b0;
    end
  end

  // divider commands issued by the sequencer
  always_comb begin
    div_cmd = '0;
    unique case (state_r)
      S_EXEC: begin
        if (req_r == REQ_ADVANCE) begin
          div_cmd.start = 1'b1;
          div_cmd.num   = DIV_NUM_W'(real_scaled);
          div_cmd.den   = {1'b0, rate_eff, 25'd0};
          div_cmd.steps = STEPS_RATE;
        end
      end
      S_DEC_H: begin
        div_cmd.start = 1'b1;
        div_cmd.num   = dm_ext;
        div_cmd.den   = DIV_DEN_W'(MS_PER_HOUR) << 4;
        div_cmd.steps = STEPS_HOUR;
      end
      S_WAIT_H: begin
        div_cmd.start = !div_busy;
        div_cmd.num   = div_rem;
        div_cmd.den   = DIV_DEN_W'(MS_PER_MIN) << 5;
        div_cmd.steps = STEPS_MIN;
      end
      S_WAIT_M: begin
        div_cmd.start = !div_busy;
        div_cmd.num   = div_rem;
        div_cmd.den   = DIV_DEN_W'(MS_PER_SEC) << 5;
        div_cmd.steps = STEPS_SEC;
      end
      default: div_cmd = '0;
    endcase
  end

  // sequencer, clock state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      day_count_r  <= '0;
      day_millis_r <= '0;
      rate_r       <= 16'd1000;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        rate_r <= cfg_data;
      end
      // the output state reloads the register itself
      if (out_valid_r && out_tready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            req_r   <= in_tuser;
            day_r   <= in_tdata[15:0];
            h_r     <= in_tdata[23:16];
            m_r     <= in_tdata[31:24];
            s_r     <= in_tdata[39:32];
            ms_r    <= in_tdata[55:40];
            unit_r  <= in_tdata[58:56];
            down_r  <= in_tdata[59];
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (req_r)
            REQ_SET_ABS, REQ_SET_DAY: begin
              ok_r    <= 1'b0;
              acc_r   <= set_a;
              state_r <= set_valid ? S_SET_B : S_DEC_H;
            end
            REQ_STEP: begin
              ok_r         <= step_ok;
              day_millis_r <= step_dm;
              day_count_r  <= step_day;
              state_r      <= S_DEC_H;
            end
            default: begin
              ok_r    <= 1'b0;
              state_r <= S_RATE_WAIT;
            end
          endcase
        end
        S_SET_B: begin
          acc_r   <= set_b;
          state_r <= S_SET_C;
        end
        S_SET_C: begin
          day_millis_r <= set_c;
          if (req_r == REQ_SET_ABS) begin
            day_count_r <= day_sat;
          end
          ok_r    <= 1'b1;
          state_r <= S_DEC_H;
        end
        S_RATE_WAIT: begin
          if (!div_busy) begin
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          if (div_quo != '0) begin
            day_millis_r <= sum_wrap[26:0];
            day_count_r  <= day_roll;
            ok_r         <= 1'b1;
          end
          state_r <= S_DEC_H;
        end
        S_DEC_H: begin
          state_r <= S_WAIT_H;
        end
        S_WAIT_H: begin
          if (!div_busy) begin
            hour_r  <= div_quo[4:0];
            state_r <= S_WAIT_M;
          end
        end
        S_WAIT_M: begin
          if (!div_busy) begin
            min_r   <= div_quo[5:0];
            state_r <= S_WAIT_S;
          end
        end
        S_WAIT_S: begin
          if (!div_busy) begin
            sec_r   <= div_quo[5:0];
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_user_r  <= ok_r;
            out_data_r  <= {2'b00, day_millis_r, div_rem[9:0], sec_r, min_r, hour_r,
                            day_now_ext[15:0]};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign day_now_ext = CW'(day_count_r);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign cfg_ready  = 1'b1;

endmodule
